>>> rtl/mpp_pkg.sv
package mpp_pkg;

  localparam int unsigned MPP_MAX_WIDTH = 1024;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned RESID_W  = 9;
  localparam int unsigned CFG_W_W  = 11;
  localparam int unsigned CFG_H_W  = 16;
  localparam int unsigned CFG_D_W  = 16;
  localparam int unsigned CFG_I_W  = 1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;

  // register indexes of the configuration port
  localparam logic [CFG_I_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // position flags that travel with each sample
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic plane_end;
  } mpp_pos_t;

endpackage

>>> rtl/mpp_line_buf.sv
module mpp_line_buf
  import mpp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MPP_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [CW-1:0]       addr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // read the old entry and replace it with the new sample in the same cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mpp_position.sv
module mpp_position
  import mpp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MPP_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_I_W-1:0] cfg_index_i,
  input  logic [CFG_D_W-1:0] cfg_data_i,
  input  logic               advance_i,
  output logic [CW-1:0]      col_o,
  output mpp_pos_t           pos_o
);

  localparam int unsigned EW = (CW + 1 > CFG_W_W) ? CW + 1 : CFG_W_W;

  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  logic [CW-1:0]      col_q, col_d;
  logic [CFG_H_W-1:0] row_q, row_d;
  logic [EW-1:0]      last_col;
  logic [CFG_H_W-1:0] last_row;
  logic               end_row, end_plane;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the width to 1..MAX_WIDTH and the height to at least 1
  always_comb begin
    if (width_q == '0) begin
      last_col = '0;
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      last_col = EW'(MAX_WIDTH - 1);
    end else begin
      last_col = EW'(width_q) - EW'(1);
    end
    last_row = (height_q == '0) ? '0 : height_q - CFG_H_W'(1);
  end

  assign end_row   = EW'(col_q) >= last_col;
  assign end_plane = end_row && (row_q >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_plane ? '0 : row_q + CFG_H_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o           = col_q;
  assign pos_o.first_col = (col_q == '0);
  assign pos_o.first_row = (row_q == '0);
  assign pos_o.plane_end = end_plane;

endmodule

>>> rtl/mpp_predict.sv
module mpp_predict
  import mpp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  mpp_pos_t            pos_i,
  input  logic [SAMPLE_W-1:0] above_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] prediction_o,
  output logic [RESID_W-1:0]  residual_o,
  output logic                plane_end_o
);

  logic                stg_valid_q, stg_valid_d;
  logic [SAMPLE_W-1:0] stg_sample_q;
  mpp_pos_t            stg_pos_q;
  logic [SAMPLE_W-1:0] left_q, upleft_q;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] pred_q;
  logic [RESID_W-1:0]  resid_q;
  logic                end_q;

  logic                accept, advance;
  logic [SAMPLE_W-1:0] a, b, c, lo, hi, pred;
  logic [SAMPLE_W+1:0] grad;

  assign advance    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // neighbours, zeroed on the first row and first column
  always_comb begin
    a    = stg_pos_q.first_col ? '0 : left_q;
    b    = stg_pos_q.first_row ? '0 : above_i;
    c    = (stg_pos_q.first_col || stg_pos_q.first_row) ? '0 : upleft_q;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    grad = {2'b00, a} + {2'b00, b} - {2'b00, c};
    if (c <= lo) begin
      pred = hi;
    end else if (c >= hi) begin
      pred = lo;
    end else begin
      pred = grad[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (advance) begin
      stg_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      upleft_q    <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        left_q   <= stg_sample_q;
        upleft_q <= above_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_sample_q <= sample_i;
      stg_pos_q    <= pos_i;
    end
    if (advance) begin
      pred_q  <= pred;
      resid_q <= {1'b0, stg_sample_q} - {1'b0, pred};
      end_q   <= stg_pos_q.plane_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = pred_q;
  assign residual_o   = resid_q;
  assign plane_end_o  = end_q;

endmodule

>>> rtl/med_pixel_predictor_top.sv
// Path: an accepted request is held in the stage register, and its result is then
// registered in the result register, from which it is taken.
// Throughput: one request per cycle while results are taken; the line buffer is read and
// written once per request. A waiting result stalls input once one more request is staged.
// Reset (rst_ni low, asynchronous): clears counters, neighbours and valid flags, sets
// width 640 and height 480; the line buffer is not cleared and needs no sweep.
module med_pixel_predictor_top
  import mpp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MPP_MAX_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_I_W-1:0]  cfg_index_i,
  input  logic [CFG_D_W-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] prediction_o,
  output logic [RESID_W-1:0]  residual_o,
  output logic                plane_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic                accept;
  logic [CW-1:0]       col;
  mpp_pos_t            pos;
  logic [SAMPLE_W-1:0] above;

  assign accept = in_valid_i && in_ready_o;

  // Position counters: advance on every accepted request, wrap at plane end.
  mpp_position #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (accept),
    .col_o       (col),
    .pos_o       (pos)
  );

  // Line buffer: fetch the sample above and store the current one at the same
  // column on acceptance. The registered read lines up with the stage register,
  // and a one-column row sees the entry written by the previous request.
  mpp_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (col),
    .wdata_i (sample_i),
    .rdata_o (above)
  );

  // Stage register, median edge detector and result register.
  mpp_predict u_predict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .pos_i        (pos),
    .above_i      (above),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prediction_o (prediction_o),
    .residual_o   (residual_o),
    .plane_end_o  (plane_end_o)
  );

endmodule

>>> rtl/mpp_checker.sv
module mpp_checker
  import mpp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SAMPLE_W-1:0] prediction_o,
  input logic [RESID_W-1:0]  residual_o,
  input logic                plane_end_o
);

  logic [RESID_W:0] sample_back;

  assign sample_back = {residual_o[RESID_W-1], residual_o} + {2'b00, prediction_o};

  // a reset edge leaves no result showing at the following edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // an empty result register always frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // residual plus prediction must give back an 8-bit sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_back[RESID_W:SAMPLE_W] == 2'b00))
    else $error("residual inconsistent with prediction");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prediction_o)
      && $stable(residual_o) && $stable(plane_end_o))
    else $error("stalled result changed");

endmodule

bind med_pixel_predictor_top mpp_checker u_mpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .prediction_o (prediction_o),
  .residual_o   (residual_o),
  .plane_end_o  (plane_end_o)
);
